>>> hw/rtl/trend_gated_fan_speed_control_assert.svh
// Assertion macros for the trend-gated fan speed controller.
// Expects signals named clk and rst in the scope where the macros are used.
`ifndef TREND_GATED_FAN_SPEED_CONTROL_ASSERT_SVH
`define TREND_GATED_FAN_SPEED_CONTROL_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define TGFSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define TGFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tgfsc_pkg.sv
// Shared types and constants for the trend-gated fan speed controller.
// No dependencies; used by the channel interfaces and the top level.
package tgfsc_pkg;

  // Field widths.
  localparam int SENSOR_W   = 17;
  localparam int AVG_W      = 8;
  localparam int SPEED_W    = 13;
  localparam int CHANGES_W  = 16;
  localparam int BASE_W     = 7;
  localparam int GAIN_W     = 10;
  localparam int TREND_W    = 4;
  localparam int PERIOD_W   = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_TEMP       = 3'd0,
    REG_SPEED_GAIN      = 3'd1,
    REG_MIN_SPEED       = 3'd2,
    REG_MAX_SPEED       = 3'd3,
    REG_TREND_LENGTH    = 3'd4,
    REG_REASSERT_PERIOD = 3'd5
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [BASE_W-1:0]   BASE_TEMP_RST       = 7'd38;
  localparam logic [GAIN_W-1:0]   SPEED_GAIN_RST      = 10'd160;
  localparam logic [SPEED_W-1:0]  MIN_SPEED_RST       = 13'd2000;
  localparam logic [SPEED_W-1:0]  MAX_SPEED_RST       = 13'd5700;
  localparam logic [TREND_W-1:0]  TREND_LENGTH_RST    = 4'd3;
  localparam logic [PERIOD_W-1:0] REASSERT_PERIOD_RST = 6'd9;

  // The average is (a + b) / 2000 = ((a + b) >> 4) / 125. The quotient by 125 is
  // taken as a multiply by ceil(2^21 / 125) and a shift by 21, which is exact for
  // every 14-bit dividend.
  localparam int SUM_W       = SENSOR_W + 1;
  localparam int AVG_PRESHIFT = 4;
  localparam int SCALED_W    = SUM_W - AVG_PRESHIFT;
  localparam int AVG_SHIFT   = 21;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] AVG_RECIP = 15'd16778;
  localparam int AVG_PROD_W  = SCALED_W + RECIP_W;

  // Signed speed product: a 10-bit difference times an 11-bit gain.
  localparam int DIFF_W      = AVG_W + 2;
  localparam int SPROD_W     = DIFF_W + GAIN_W + 1;

  localparam logic [TREND_W-1:0] RUN_MAX = 4'd15;

endpackage

>>> hw/rtl/tgfsc_if.sv
// Valid/ready channel interfaces of the trend-gated fan speed controller.
// Depends on tgfsc_pkg for field widths.

interface tgfsc_sample_if;
  logic                            valid;
  logic                            ready;
  logic [tgfsc_pkg::SENSOR_W-1:0]  sensor_a_milli;
  logic [tgfsc_pkg::SENSOR_W-1:0]  sensor_b_milli;

  modport source (output valid, output sensor_a_milli, output sensor_b_milli, input ready);
  modport sink   (input valid, input sensor_a_milli, input sensor_b_milli, output ready);
endinterface

interface tgfsc_result_if;
  logic                            valid;
  logic                            ready;
  logic [tgfsc_pkg::SPEED_W-1:0]   speed_cmd;
  logic                            speed_write;
  logic                            manual_reassert;
  logic [tgfsc_pkg::CHANGES_W-1:0] changes_made;
  logic [tgfsc_pkg::AVG_W-1:0]     avg_temp;

  modport source (output valid, output speed_cmd, output speed_write, output manual_reassert,
                  output changes_made, output avg_temp, input ready);
  modport sink   (input valid, input speed_cmd, input speed_write, input manual_reassert,
                  input changes_made, input avg_temp, output ready);
endinterface

interface tgfsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tgfsc_pkg::CFG_IDX_W-1:0]  index;
  logic [tgfsc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/trend_gated_fan_speed_control.sv
// Top level of the trend-gated fan speed controller: pipeline, trend state and registers.
// Depends on tgfsc_pkg, the interfaces in tgfsc_if.sv and the assertion macro header.
`include "trend_gated_fan_speed_control_assert.svh"

// Each beat on the sample channel carries two CPU temperatures in millidegrees and
// produces exactly one beat on the result channel, in the order the samples were
// accepted. Unless back-pressure stalls it, the block takes one sample in every
// cycle: three registered stages (the average, the clamped speed law, and the trend
// state update) each hold one beat, so a new sample is taken while earlier ones are in
// flight and while a finished result waits to be taken. Back-pressure from the result
// channel only stops the sample channel once all three stages are full. The first
// sample after reset always commands a speed and raises the manual mode reassert; later
// samples command a speed only when a run of rises or falls reaches the trend length and
// the clamped speed differs from the last one a run wrote. The configuration channel is
// always ready and takes one register write per beat; registers should be written only
// while no sample is in flight, since a write takes effect on the very next cycle.
module trend_gated_fan_speed_control (
  input  logic           clk,
  input  logic           rst,
  tgfsc_sample_if.sink   sample,
  tgfsc_result_if.source result,
  tgfsc_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [tgfsc_pkg::BASE_W-1:0]   base_temp;
  logic [tgfsc_pkg::GAIN_W-1:0]   speed_gain;
  logic [tgfsc_pkg::SPEED_W-1:0]  floor_speed;
  logic [tgfsc_pkg::SPEED_W-1:0]  ceiling_speed;
  logic [tgfsc_pkg::TREND_W-1:0]  trend_length;
  logic [tgfsc_pkg::PERIOD_W-1:0] reassert_period;

  // Pipeline occupancy and the load enables derived from it.
  logic s1_valid, s2_valid, out_valid;
  logic out_load, s2_load, s1_load;
  logic take_sample, step;

  // Stage payloads.
  logic [tgfsc_pkg::SUM_W-1:0]      sensor_sum;
  logic [tgfsc_pkg::AVG_PROD_W-1:0] avg_prod;
  logic [tgfsc_pkg::AVG_W-1:0]      avg_calc;
  logic [tgfsc_pkg::AVG_W-1:0]      s1_avg;

  logic signed [tgfsc_pkg::DIFF_W-1:0]  temp_diff;
  logic signed [tgfsc_pkg::SPROD_W-1:0] speed_raw;
  logic signed [tgfsc_pkg::SPROD_W-1:0] speed_lo;
  logic signed [tgfsc_pkg::SPROD_W-1:0] speed_hi;
  logic [tgfsc_pkg::AVG_W-1:0]          s2_avg;
  logic [tgfsc_pkg::SPEED_W-1:0]        s2_speed;

  // Trend state.
  logic                             started, started_next;
  logic [tgfsc_pkg::AVG_W-1:0]      prev_avg, prev_avg_next;
  logic [tgfsc_pkg::TREND_W-1:0]    fall_run, fall_run_next;
  logic [tgfsc_pkg::TREND_W-1:0]    rise_run, rise_run_next;
  logic [tgfsc_pkg::SPEED_W-1:0]    last_speed, last_speed_next;
  logic                             last_speed_valid, last_speed_valid_next;
  logic [tgfsc_pkg::PERIOD_W-1:0]   reassert_count, reassert_count_next;
  logic [tgfsc_pkg::PERIOD_W-1:0]   reassert_inc;
  logic [tgfsc_pkg::CHANGES_W-1:0]  change_total, change_total_next;
  logic                             fire;

  // Result register and its next values.
  logic [tgfsc_pkg::SPEED_W-1:0]    speed_cmd, speed_cmd_next;
  logic                             speed_write, speed_write_next;
  logic                             manual_reassert, manual_reassert_next;
  logic [tgfsc_pkg::CHANGES_W-1:0]  changes_made;
  logic [tgfsc_pkg::AVG_W-1:0]      avg_temp;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to indexes beyond the register list are
  // accepted and ignored; each register keeps only its own low bits.
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_temp       <= tgfsc_pkg::BASE_TEMP_RST;
      speed_gain      <= tgfsc_pkg::SPEED_GAIN_RST;
      floor_speed     <= tgfsc_pkg::MIN_SPEED_RST;
      ceiling_speed   <= tgfsc_pkg::MAX_SPEED_RST;
      trend_length    <= tgfsc_pkg::TREND_LENGTH_RST;
      reassert_period <= tgfsc_pkg::REASSERT_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tgfsc_pkg::REG_BASE_TEMP:       base_temp       <= cfg.data[tgfsc_pkg::BASE_W-1:0];
        tgfsc_pkg::REG_SPEED_GAIN:      speed_gain      <= cfg.data[tgfsc_pkg::GAIN_W-1:0];
        tgfsc_pkg::REG_MIN_SPEED:       floor_speed     <= cfg.data[tgfsc_pkg::SPEED_W-1:0];
        tgfsc_pkg::REG_MAX_SPEED:       ceiling_speed   <= cfg.data[tgfsc_pkg::SPEED_W-1:0];
        tgfsc_pkg::REG_TREND_LENGTH:    trend_length    <= cfg.data[tgfsc_pkg::TREND_W-1:0];
        tgfsc_pkg::REG_REASSERT_PERIOD: reassert_period <= cfg.data[tgfsc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage may load when it is empty or when its contents move on
  // in the same cycle, so bubbles are squeezed out and the sample side keeps
  // moving while a result waits.
  // ---------------------------------------------------------------------------
  assign out_load     = !out_valid || result.ready;
  assign s2_load      = !s2_valid || out_load;
  assign s1_load      = !s1_valid || s2_load;
  assign sample.ready = s1_load;
  assign take_sample  = sample.valid && s1_load;
  assign step         = s2_valid && out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= sample.valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (out_load) begin
        out_valid <= s2_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: average in whole degrees. The sum of the two readings is divided by
  // 2000 as a shift by four followed by a reciprocal multiply for the factor 125.
  // ---------------------------------------------------------------------------
  assign sensor_sum = {1'b0, sample.sensor_a_milli} + {1'b0, sample.sensor_b_milli};
  assign avg_prod   = sensor_sum[tgfsc_pkg::SUM_W-1:tgfsc_pkg::AVG_PRESHIFT]
                      * tgfsc_pkg::AVG_RECIP;
  assign avg_calc   = avg_prod[tgfsc_pkg::AVG_SHIFT +: tgfsc_pkg::AVG_W];

  always_ff @(posedge clk) begin
    if (take_sample) begin
      s1_avg <= avg_calc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: linear speed law and clamp. The product is signed since the average
  // may sit below the base temperature. The minimum is applied first and the
  // maximum last, so a minimum above the maximum yields the maximum.
  // ---------------------------------------------------------------------------
  assign temp_diff = $signed({2'b00, s1_avg}) - $signed({3'b000, base_temp});
  assign speed_raw = temp_diff * $signed({1'b0, speed_gain});
  assign speed_lo  = (speed_raw < $signed({8'b0, floor_speed})) ?
                     $signed({8'b0, floor_speed}) : speed_raw;
  assign speed_hi  = (speed_lo > $signed({8'b0, ceiling_speed})) ?
                     $signed({8'b0, ceiling_speed}) : speed_lo;

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_avg   <= s1_avg;
      s2_speed <= speed_hi[tgfsc_pkg::SPEED_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: trend tracking. The first beat after reset seeds the state and
  // always commands a speed. Later beats advance the reassert counter, extend
  // or break the rise and fall runs (a flat reading leaves both alone), and on
  // a completed run write the speed if it differs from the last one a run wrote.
  // ---------------------------------------------------------------------------
  assign reassert_inc = reassert_count + 6'd1;

  always_comb begin
    started_next          = started;
    prev_avg_next         = prev_avg;
    fall_run_next         = fall_run;
    rise_run_next         = rise_run;
    last_speed_next       = last_speed;
    last_speed_valid_next = last_speed_valid;
    reassert_count_next   = reassert_count;
    change_total_next     = change_total;
    speed_cmd_next        = '0;
    speed_write_next      = 1'b0;
    manual_reassert_next  = 1'b0;
    fire                  = 1'b0;

    if (!started) begin
      started_next         = 1'b1;
      prev_avg_next        = s2_avg;
      fall_run_next        = (trend_length != '0) ? trend_length - 4'd1 : '0;
      rise_run_next        = fall_run_next;
      speed_cmd_next       = s2_speed;
      speed_write_next     = 1'b1;
      manual_reassert_next = 1'b1;
    end else begin
      if (reassert_inc >= reassert_period) begin
        manual_reassert_next = 1'b1;
        reassert_count_next  = '0;
      end else begin
        reassert_count_next  = reassert_inc;
      end

      if (s2_avg < prev_avg) begin
        fall_run_next = (fall_run == tgfsc_pkg::RUN_MAX) ? fall_run : fall_run + 4'd1;
        rise_run_next = '0;
      end else if (s2_avg > prev_avg) begin
        rise_run_next = (rise_run == tgfsc_pkg::RUN_MAX) ? rise_run : rise_run + 4'd1;
        fall_run_next = '0;
      end

      fire = (fall_run_next >= trend_length) || (rise_run_next >= trend_length);
      if (fire) begin
        if (!last_speed_valid || (s2_speed != last_speed)) begin
          speed_cmd_next        = s2_speed;
          speed_write_next      = 1'b1;
          change_total_next     = change_total + 16'd1;
          last_speed_next       = s2_speed;
          last_speed_valid_next = 1'b1;
        end
        fall_run_next = '0;
        rise_run_next = '0;
      end

      prev_avg_next = s2_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      prev_avg         <= '0;
      fall_run         <= '0;
      rise_run         <= '0;
      last_speed       <= '0;
      last_speed_valid <= 1'b0;
      reassert_count   <= '0;
      change_total     <= '0;
    end else if (step) begin
      started          <= started_next;
      prev_avg         <= prev_avg_next;
      fall_run         <= fall_run_next;
      rise_run         <= rise_run_next;
      last_speed       <= last_speed_next;
      last_speed_valid <= last_speed_valid_next;
      reassert_count   <= reassert_count_next;
      change_total     <= change_total_next;
    end
  end

  // Result register: holds its beat until the result side takes it.
  always_ff @(posedge clk) begin
    if (step) begin
      speed_cmd       <= speed_cmd_next;
      speed_write     <= speed_write_next;
      manual_reassert <= manual_reassert_next;
      changes_made    <= change_total_next;
      avg_temp        <= s2_avg;
    end
  end

  assign result.valid           = out_valid;
  assign result.speed_cmd       = speed_cmd;
  assign result.speed_write     = speed_write;
  assign result.manual_reassert = manual_reassert;
  assign result.changes_made    = changes_made;
  assign result.avg_temp        = avg_temp;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `TGFSC_ASSERT_NOW(a_full_stalls_input,
    s1_valid && s2_valid && out_valid && !result.ready, !sample.ready,
    "sample taken while every stage is full and the result is stalled")

  `TGFSC_ASSERT_NEXT(a_step_fills_output, step, out_valid,
    "trend step did not leave a result in the output register")

  `TGFSC_ASSERT_NOW(a_speed_in_range,
    out_valid && speed_write && (floor_speed <= ceiling_speed),
    (speed_cmd >= floor_speed) && (speed_cmd <= ceiling_speed),
    "commanded speed lies outside the clamp range")

  `TGFSC_ASSERT_NOW(a_last_speed_after_start, last_speed_valid, started,
    "a trend speed is recorded before the first sample was seen")

endmodule

>>> test/fan_speed_checker.sv
// Checker for the trend-gated fan speed controller: watches the three channels,
// predicts each result beat and compares it field by field.
// Depends on tgfsc_pkg and the channel interfaces in tgfsc_if.sv.
module fan_speed_checker (
  input  logic    clk,
  input  logic    rst,
  tgfsc_sample_if sample,
  tgfsc_result_if result,
  tgfsc_cfg_if    cfg,
  output int      mismatches,
  output int      in_flight,
  output int      results_checked,
  output int      speed_writes,
  output int      reassert_pulses
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSOR_W  = tgfsc_pkg::SENSOR_W;
  localparam int SPEED_W   = tgfsc_pkg::SPEED_W;
  localparam int CHANGES_W = tgfsc_pkg::CHANGES_W;
  localparam int AVG_W     = tgfsc_pkg::AVG_W;
  localparam int BASE_W    = tgfsc_pkg::BASE_W;
  localparam int GAIN_W    = tgfsc_pkg::GAIN_W;
  localparam int TREND_W   = tgfsc_pkg::TREND_W;
  localparam int PERIOD_W  = tgfsc_pkg::PERIOD_W;

  typedef struct packed {
    logic [SPEED_W-1:0]   speed_cmd;
    logic                 speed_write;
    logic                 manual_reassert;
    logic [CHANGES_W-1:0] changes_made;
    logic [AVG_W-1:0]     avg_temp;
  } fan_result_t;

  // Register copies.
  logic [BASE_W-1:0]   base_deg;
  logic [GAIN_W-1:0]   gain_rpm;
  logic [SPEED_W-1:0]  floor_rpm;
  logic [SPEED_W-1:0]  ceil_rpm;
  logic [TREND_W-1:0]  trend_len;
  logic [PERIOD_W-1:0] period_len;

  // Controller state.
  bit                   primed;
  logic [AVG_W-1:0]     prev_deg;
  logic [TREND_W-1:0]   falls;
  logic [TREND_W-1:0]   rises;
  logic [SPEED_W-1:0]   last_cmd;
  bit                   last_cmd_ok;
  logic [PERIOD_W-1:0]  pulse_count;
  logic [CHANGES_W-1:0] change_count;

  fan_result_t expected_q[$];
  int error_count = 0;
  int checked_n = 0;
  int writes_n = 0;
  int pulses_n = 0;

  // Linear speed law, minimum clamp first and then maximum.
  function automatic logic [SPEED_W-1:0] law_speed(logic [AVG_W-1:0] deg);
    longint s;
    s = (longint'(deg) - longint'(base_deg)) * longint'(gain_rpm);
    if (s < longint'(floor_rpm)) s = longint'(floor_rpm);
    if (s > longint'(ceil_rpm)) s = longint'(ceil_rpm);
    return s[SPEED_W-1:0];
  endfunction

  function automatic logic [TREND_W-1:0] run_step(logic [TREND_W-1:0] v);
    return (v == tgfsc_pkg::RUN_MAX) ? tgfsc_pkg::RUN_MAX : v + 1'b1;
  endfunction

  // Advances the controller state by one sample and returns the result it causes.
  function automatic fan_result_t step_controller(logic [SENSOR_W-1:0] a,
                                                  logic [SENSOR_W-1:0] b);
    fan_result_t r;
    logic [SPEED_W-1:0] law;
    int deg;
    deg = (int'(a) + int'(b)) / 2000;
    r = '0;
    r.avg_temp = AVG_W'(deg);
    if (!primed) begin
      primed = 1'b1;
      prev_deg = r.avg_temp;
      falls = (trend_len != 0) ? trend_len - 1'b1 : '0;
      rises = falls;
      r.speed_cmd = law_speed(r.avg_temp);
      r.speed_write = 1'b1;
      r.manual_reassert = 1'b1;
    end else begin
      pulse_count = pulse_count + 1'b1;
      if (pulse_count >= period_len) begin
        r.manual_reassert = 1'b1;
        pulse_count = '0;
      end
      if (r.avg_temp < prev_deg) begin
        falls = run_step(falls);
        rises = '0;
      end else if (r.avg_temp > prev_deg) begin
        rises = run_step(rises);
        falls = '0;
      end
      if (falls >= trend_len || rises >= trend_len) begin
        law = law_speed(r.avg_temp);
        if (!last_cmd_ok || law != last_cmd) begin
          r.speed_cmd = law;
          r.speed_write = 1'b1;
          change_count = change_count + 1'b1;
          last_cmd = law;
          last_cmd_ok = 1'b1;
        end
        falls = '0;
        rises = '0;
      end
      prev_deg = r.avg_temp;
    end
    r.changes_made = change_count;
    return r;
  endfunction

  task automatic report_field(string field, logic [CHANGES_W-1:0] want,
                              logic [CHANGES_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : monitor
    fan_result_t got;
    fan_result_t want;
    if (rst) begin
      base_deg     = tgfsc_pkg::BASE_TEMP_RST;
      gain_rpm     = tgfsc_pkg::SPEED_GAIN_RST;
      floor_rpm    = tgfsc_pkg::MIN_SPEED_RST;
      ceil_rpm     = tgfsc_pkg::MAX_SPEED_RST;
      trend_len    = tgfsc_pkg::TREND_LENGTH_RST;
      period_len   = tgfsc_pkg::REASSERT_PERIOD_RST;
      primed       = 1'b0;
      prev_deg     = '0;
      falls        = '0;
      rises        = '0;
      last_cmd     = '0;
      last_cmd_ok  = 1'b0;
      pulse_count  = '0;
      change_count = '0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (tgfsc_pkg::cfg_reg_t'(cfg.index))
          tgfsc_pkg::REG_BASE_TEMP:       base_deg   = cfg.data[BASE_W-1:0];
          tgfsc_pkg::REG_SPEED_GAIN:      gain_rpm   = cfg.data[GAIN_W-1:0];
          tgfsc_pkg::REG_MIN_SPEED:       floor_rpm  = cfg.data[SPEED_W-1:0];
          tgfsc_pkg::REG_MAX_SPEED:       ceil_rpm   = cfg.data[SPEED_W-1:0];
          tgfsc_pkg::REG_TREND_LENGTH:    trend_len  = cfg.data[TREND_W-1:0];
          tgfsc_pkg::REG_REASSERT_PERIOD: period_len = cfg.data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      // A result never leaves in the cycle its sample is taken, so compare before predicting.
      if (result.valid && result.ready) begin
        got = {result.speed_cmd, result.speed_write, result.manual_reassert,
               result.changes_made, result.avg_temp};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got avg_temp %0d",
                   $time, got.avg_temp);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.speed_cmd !== want.speed_cmd)
            report_field("speed_cmd", want.speed_cmd, got.speed_cmd);
          if (got.speed_write !== want.speed_write)
            report_field("speed_write", want.speed_write, got.speed_write);
          if (got.manual_reassert !== want.manual_reassert)
            report_field("manual_reassert", want.manual_reassert, got.manual_reassert);
          if (got.changes_made !== want.changes_made)
            report_field("changes_made", want.changes_made, got.changes_made);
          if (got.avg_temp !== want.avg_temp)
            report_field("avg_temp", want.avg_temp, got.avg_temp);
          checked_n++;
          if (want.speed_write) writes_n++;
          if (want.manual_reassert) pulses_n++;
        end
      end
      if (sample.valid && sample.ready)
        expected_q.push_back(step_controller(sample.sensor_a_milli, sample.sensor_b_milli));
    end
    in_flight       <= expected_q.size();
    mismatches      <= error_count;
    results_checked <= checked_n;
    speed_writes    <= writes_n;
    reassert_pulses <= pulses_n;
  end

endmodule

>>> test/tb.sv
// Testbench top for the trend-gated fan speed controller: clock, reset, sample and
// register stimulus, result back-pressure and the final verdict.
// Depends on tgfsc_pkg, tgfsc_if.sv, the block itself and fan_speed_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSOR_W   = tgfsc_pkg::SENSOR_W;
  localparam int CFG_IDX_W  = tgfsc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tgfsc_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int RANDOM_PHASES    = 10;
  localparam int PHASE_ITEMS      = 36;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int ALT_ITEMS        = 20;
  localparam int ALT_LOW_DEG      = 10;
  localparam int SETTLE_CYCLES    = 8;
  localparam int MAX_DEG          = 131;
  localparam int SENSOR_TOP       = 131_071;
  localparam logic [SENSOR_W-1:0] SENSOR_MAX = '1;
  // Indexes beyond the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  tgfsc_sample_if sample_ch ();
  tgfsc_result_if result_ch ();
  tgfsc_cfg_if    cfg_ch ();

  int mismatches;
  int in_flight;
  int results_checked;
  int speed_writes;
  int reassert_pulses;

  trend_gated_fan_speed_control dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  fan_speed_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample_ch),
    .result          (result_ch),
    .cfg             (cfg_ch),
    .mismatches      (mismatches),
    .in_flight       (in_flight),
    .results_checked (results_checked),
    .speed_writes    (speed_writes),
    .reassert_pulses (reassert_pulses)
  );

  // Controls shared between the stimulus and the result back-pressure process.
  bit tx_idling = 1'b0;
  bit rx_idling = 1'b0;
  bit long_hold = 1'b0;

  int cycle_count = 0;
  int settings_applied = 0;
  int cur_deg = 50;
  reg_write_t reg_writes[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: fails the run if it reaches the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.", in_flight);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result back-pressure. The long hold-off keeps ready low for a fixed stretch so
  // that all three pipeline stages fill and the sample channel is stalled.
  initial begin : result_backpressure
    result_ch.ready <= 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Offers one sample beat and returns at the edge that accepts it. Valid is left high
  // so that back-to-back beats need no second assignment in the same time step.
  task automatic send_sample(input logic [SENSOR_W-1:0] a, input logic [SENSOR_W-1:0] b);
    sample_ch.valid          <= 1'b1;
    sample_ch.sensor_a_milli <= a;
    sample_ch.sensor_b_milli <= b;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic pause_samples(input int cycles);
    sample_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sends a sample, sometimes after a burst of idle cycles on the sample side.
  task automatic offer_sample(input logic [SENSOR_W-1:0] a, input logic [SENSOR_W-1:0] b);
    if (tx_idling && $urandom_range(0, 4) == 0)
      pause_samples($urandom_range(1, 18));
    send_sample(a, b);
  endtask

  // Splits a target temperature in whole degrees into two random sensor readings whose
  // sum, divided by 2000, gives that temperature.
  task automatic send_degrees(input int deg);
    int sum;
    int lo;
    int hi;
    int a;
    sum = deg * 2000 + $urandom_range(0, 1999);
    if (sum > 2 * SENSOR_TOP) sum = 2 * SENSOR_TOP;
    lo = (sum > SENSOR_TOP) ? sum - SENSOR_TOP : 0;
    hi = (sum < SENSOR_TOP) ? sum : SENSOR_TOP;
    a = $urandom_range(hi, lo);
    offer_sample(SENSOR_W'(a), SENSOR_W'(sum - a));
  endtask

  // Stops offering samples and waits until every predicted result has been taken.
  // The first edge lets the checker count a beat accepted in this very step.
  task automatic wait_until_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data  = data;
    reg_writes.push_back(w);
  endtask

  // Register writes go out back to back, and only once the pipeline is empty.
  task automatic apply_register_writes();
    reg_write_t w;
    wait_until_drained();
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= w.index;
      cfg_ch.data  <= w.data;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  // A register value: either end of the data field, any pattern at all, or a value
  // from the range that keeps the speed law between the clamps for normal readings.
  function automatic logic [CFG_DATA_W-1:0] pick_register_value(tgfsc_pkg::cfg_reg_t r);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom());
      default: begin
        case (r)
          tgfsc_pkg::REG_BASE_TEMP:    return CFG_DATA_W'($urandom_range(20, 60));
          tgfsc_pkg::REG_SPEED_GAIN:   return CFG_DATA_W'($urandom_range(20, 300));
          tgfsc_pkg::REG_MIN_SPEED:    return CFG_DATA_W'($urandom_range(0, 3000));
          tgfsc_pkg::REG_MAX_SPEED:    return CFG_DATA_W'($urandom_range(3000, 8191));
          tgfsc_pkg::REG_TREND_LENGTH: return CFG_DATA_W'($urandom_range(1, 5));
          default:                     return CFG_DATA_W'($urandom_range(1, 20));
        endcase
      end
    endcase
  endfunction

  // Programs every register; the first two random phases take the top and the bottom
  // of every field, later ones mix extremes with random and realistic values.
  task automatic program_setting(input int phase);
    logic [CFG_DATA_W-1:0] value;
    for (int r = tgfsc_pkg::REG_BASE_TEMP; r <= tgfsc_pkg::REG_REASSERT_PERIOD; r++) begin
      if (phase == 0) value = '1;
      else if (phase == 1) value = '0;
      else value = pick_register_value(tgfsc_pkg::cfg_reg_t'(r));
      queue_write(CFG_IDX_W'(r), value);
    end
    if ($urandom_range(0, 1) == 0) begin
      queue_write(IDX_SPARE_LO, CFG_DATA_W'($urandom()));
      queue_write(IDX_SPARE_HI, CFG_DATA_W'($urandom()));
    end
    apply_register_writes();
  endtask

  // Mostly runs of rising, falling or flat temperatures with random step sizes and
  // sub-degree jitter, broken up now and then by fully random sensor readings.
  task automatic run_trend_phase(input int items, input int hold_at, input int drain_at);
    int sent;
    int run_left;
    int dir;
    int step;
    sent = 0;
    run_left = 0;
    dir = 0;
    step = 1;
    while (sent < items) begin
      if (sent == hold_at) long_hold = 1'b1;
      if (sent == drain_at) wait_until_drained();
      if (run_left == 0) begin
        dir = $urandom_range(0, 2);
        run_left = $urandom_range(1, 10);
        step = $urandom_range(1, 3);
      end
      run_left--;
      if ($urandom_range(0, 99) < 12) begin
        offer_sample(SENSOR_W'($urandom()), SENSOR_W'($urandom()));
      end else begin
        if (dir == 0) cur_deg -= step;
        else if (dir == 1) cur_deg += step;
        if (cur_deg < 0) cur_deg = 0;
        if (cur_deg > MAX_DEG) cur_deg = MAX_DEG;
        send_degrees(cur_deg);
      end
      sent++;
    end
  endtask

  initial begin : stimulus
    rst                      <= 1'b1;
    sample_ch.valid          <= 1'b0;
    sample_ch.sensor_a_milli <= '0;
    sample_ch.sensor_b_milli <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= tgfsc_pkg::REG_BASE_TEMP;
    cfg_ch.data              <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at their reset values. The first beat initialises the trend state and
    // commands a speed; the full-scale readings give the highest average, then a fall,
    // a flat beat from the opposite split, a flat beat from alternating bit patterns,
    // and the lowest averages.
    send_sample('0, '0);
    send_sample(SENSOR_MAX, SENSOR_MAX);
    send_sample(SENSOR_MAX, '0);
    send_sample('0, SENSOR_MAX);
    send_sample(17'h15555, 17'h0AAAA);
    send_sample(17'd999, 17'd1000);
    send_sample(17'd1000, 17'd1000);

    // Zero trend length makes every beat recompute, and a zero period pulses on every
    // beat. With the base at its top, low readings give a negative product that the
    // minimum clamp lifts; a repeated speed must not be written twice.
    queue_write(tgfsc_pkg::REG_TREND_LENGTH, '0);
    queue_write(tgfsc_pkg::REG_REASSERT_PERIOD, '0);
    queue_write(tgfsc_pkg::REG_BASE_TEMP, '1);
    queue_write(tgfsc_pkg::REG_SPEED_GAIN, '1);
    queue_write(tgfsc_pkg::REG_MIN_SPEED, 13'd100);
    queue_write(tgfsc_pkg::REG_MAX_SPEED, '1);
    apply_register_writes();
    send_sample(SENSOR_MAX, SENSOR_MAX);
    send_sample('0, '0);
    send_sample('0, '0);
    send_sample(SENSOR_MAX, SENSOR_MAX);

    // Longest trend length and period: a short rise builds a run that cannot fire.
    queue_write(tgfsc_pkg::REG_TREND_LENGTH, 13'd15);
    queue_write(tgfsc_pkg::REG_REASSERT_PERIOD, 13'd63);
    queue_write(tgfsc_pkg::REG_BASE_TEMP, '0);
    apply_register_writes();
    send_degrees(10);
    send_degrees(20);
    send_degrees(30);
    send_degrees(40);

    // Lowering the trend length to the run already built fires on the next beat
    // even though it is flat. The minimum above the maximum leaves the maximum.
    queue_write(tgfsc_pkg::REG_TREND_LENGTH, 13'd3);
    queue_write(tgfsc_pkg::REG_MIN_SPEED, '1);
    queue_write(tgfsc_pkg::REG_MAX_SPEED, '0);
    apply_register_writes();
    send_degrees(40);
    send_degrees(40);

    // Random phases, each with a fresh register setting. Idling on either side is
    // switched off in some phases to get stretches of full rate traffic.
    for (int phase = 0; phase < RANDOM_PHASES - 1; phase++) begin
      program_setting(phase);
      tx_idling = (phase % 3 != 2);
      rx_idling = (phase % 4 != 3);
      run_trend_phase(PHASE_ITEMS, (phase == 4) ? 10 : -1, (phase == 6) ? 20 : -1);
    end

    // With a zero trend length and unit gain, alternating temperatures write a new
    // speed and advance the change counter on every beat.
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    queue_write(tgfsc_pkg::REG_TREND_LENGTH, '0);
    queue_write(tgfsc_pkg::REG_BASE_TEMP, '0);
    queue_write(tgfsc_pkg::REG_SPEED_GAIN, 13'd1);
    queue_write(tgfsc_pkg::REG_MIN_SPEED, '0);
    queue_write(tgfsc_pkg::REG_MAX_SPEED, '1);
    queue_write(tgfsc_pkg::REG_REASSERT_PERIOD,
                pick_register_value(tgfsc_pkg::REG_REASSERT_PERIOD));
    apply_register_writes();
    for (int i = 0; i < ALT_ITEMS; i++)
      send_degrees(ALT_LOW_DEG + (i % 2));

    // Final phase at full rate with no idling on either side.
    program_setting(RANDOM_PHASES - 1);
    run_trend_phase(PHASE_ITEMS, -1, -1);

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d result beats with %0d speed writes and %0d reassert pulses.",
             results_checked, speed_writes, reassert_pulses);
    $display("Covered %0d register settings, clamp extremes and a write on every beat.",
             settings_applied);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tgfsc_pkg.sv
hw/rtl/tgfsc_if.sv
hw/rtl/trend_gated_fan_speed_control.sv
test/fan_speed_checker.sv
test/tb.sv
